### rtl/lkc_pkg.sv
// ----------------------------------------------------------------------------
// lkc_pkg
// Shared constants and types for the keyed LRU lookup core.
// ----------------------------------------------------------------------------
package lkc_pkg;

    localparam int ENTRIES_DEF   = 20;
    localparam int AGE_BITS_DEF  = 32;

    localparam int X_W           = 12;
    localparam int WIDTH_W       = 13;
    localparam int SIDE_W        = 2;
    localparam int STYLE_W       = 4;
    localparam int HEADER_W      = 8;
    localparam int COUNT_W       = 8;
    localparam int KEY_W         = SIDE_W + STYLE_W + HEADER_W + COUNT_W + WIDTH_W;
    localparam int SLOT_W        = 5;

    localparam logic [WIDTH_W-1:0] SCREEN_RESET = 13'd800;
    localparam logic [WIDTH_W-1:0] LEFT_DEFAULT = 13'd1;

    typedef struct packed {
        logic key_we;
        logic age_we;
    } wr_ctl_t;

endpackage

### rtl/lkc_key.sv
// ----------------------------------------------------------------------------
// lkc_key
// Builds the lookup key from the request fields and the screen width.
// ----------------------------------------------------------------------------
module lkc_key
(
    input  logic [lkc_pkg::SIDE_W-1:0]   side,
    input  logic [lkc_pkg::STYLE_W-1:0]  style,
    input  logic [lkc_pkg::HEADER_W-1:0] header,
    input  logic [lkc_pkg::COUNT_W-1:0]  item_count,
    input  logic [lkc_pkg::X_W-1:0]      left_x,
    input  logic                         left_absent,
    input  logic [lkc_pkg::X_W-1:0]      right_x,
    input  logic                         right_absent,
    input  logic [lkc_pkg::WIDTH_W-1:0]  canvas_w,
    output logic [lkc_pkg::KEY_W-1:0]    key
);

    logic [lkc_pkg::WIDTH_W-1:0] left_edge;
    logic [lkc_pkg::WIDTH_W-1:0] right_edge;
    logic [lkc_pkg::WIDTH_W-1:0] span;

    assign left_edge  = left_absent ? lkc_pkg::LEFT_DEFAULT : {1'b0, left_x};
    assign right_edge = right_absent ? (canvas_w - lkc_pkg::WIDTH_W'(1))
                                     : {1'b0, right_x};
    assign span       = right_edge - left_edge;
    assign key        = {span, item_count, header, style, side};

endmodule

### rtl/lkc_store.sv
// ----------------------------------------------------------------------------
// lkc_store
// Key and age storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lkc_store
#(
    parameter int ENTRIES  = lkc_pkg::ENTRIES_DEF,
    parameter int AGE_BITS = lkc_pkg::AGE_BITS_DEF,
    parameter int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
)
(
    input  logic                      clk,
    input  lkc_pkg::wr_ctl_t          wctl,
    input  logic [IDX_W-1:0]          waddr,
    input  logic [lkc_pkg::KEY_W-1:0] wkey,
    input  logic [AGE_BITS-1:0]       wage,
    input  logic [IDX_W-1:0]          raddr,
    output logic [lkc_pkg::KEY_W-1:0] rkey,
    output logic [AGE_BITS-1:0]       rage
);

    logic [lkc_pkg::KEY_W-1:0] key_mem [ENTRIES];
    logic [AGE_BITS-1:0]       age_mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wctl.key_we)
        begin
            key_mem[waddr] <= wkey;
        end
        if (wctl.age_we)
        begin
            age_mem[waddr] <= wage;
        end
        rkey <= key_mem[raddr];
        rage <= age_mem[raddr];
    end

endmodule

### rtl/lru_keyed_cache_lookup_core.sv
// ----------------------------------------------------------------------------
// lru_keyed_cache_lookup_core
// Fully associative lookup table with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats arrive on in_valid/in_stall with the key fields; each
//   produces one result beat (hit, slot, evicted) on out_valid/out_stall.
//   canvas_w is written on cfg_valid/cfg_ready (always ready); the user must
//   write it only while idle, the block itself does not enforce this.
//   One request at a time: in_stall is high from accept until the result is
//   loaded into the output register. Table entries are read one per cycle
//   through the store's registered read port and compared by one shared
//   key/age comparator. A hit ends the scan at its slot; a miss scans every
//   valid entry. When the age counter wraps, a sweep rewrites the valid
//   ages first.
//   The result sits in an output register; a new request is taken while it
//   waits, and a stalled result holds until taken.
//   Reset empties the table (fill count zero), clears the age counter and
//   sets canvas_w to 800. No clearing pass over the store is needed.
// ----------------------------------------------------------------------------
module lru_keyed_cache_lookup_core
#(
    parameter int ENTRIES  = lkc_pkg::ENTRIES_DEF,
    parameter int AGE_BITS = lkc_pkg::AGE_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lkc_pkg::WIDTH_W-1:0]  cfg_data,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [lkc_pkg::SIDE_W-1:0]   side,
    input  logic [lkc_pkg::STYLE_W-1:0]  style,
    input  logic [lkc_pkg::HEADER_W-1:0] header,
    input  logic [lkc_pkg::COUNT_W-1:0]  item_count,
    input  logic [lkc_pkg::X_W-1:0]      left_x,
    input  logic                         left_absent,
    input  logic [lkc_pkg::X_W-1:0]      right_x,
    input  logic                         right_absent,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         hit,
    output logic [lkc_pkg::SLOT_W-1:0]   slot,
    output logic                         evicted
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SCAN,
        ST_OUT
    } state_t;

    state_t                    state_reg, state_next;
    logic [lkc_pkg::WIDTH_W-1:0] canvas_w_reg;
    logic [lkc_pkg::KEY_W-1:0] key_reg, key_next;
    logic [AGE_BITS-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]          fill_reg, fill_next;
    logic [CNT_W-1:0]          rd_idx_reg, rd_idx_next;
    logic                      pend_reg, pend_next;
    logic [IDX_W-1:0]          pend_idx_reg, pend_idx_next;
    logic [AGE_BITS-1:0]       least_reg, least_next;
    logic [IDX_W-1:0]          lru_reg, lru_next;
    logic                      res_hit_reg, res_hit_next;
    logic [IDX_W-1:0]          res_slot_reg, res_slot_next;
    logic                      res_ev_reg, res_ev_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      hit_reg, hit_next;
    logic [lkc_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic                      evicted_reg, evicted_next;

    logic [lkc_pkg::KEY_W-1:0] key_w;
    logic [AGE_BITS-1:0]       cnt_inc;
    lkc_pkg::wr_ctl_t          wctl;
    logic [IDX_W-1:0]          waddr;
    logic [lkc_pkg::KEY_W-1:0] wkey;
    logic [AGE_BITS-1:0]       wage;
    logic [IDX_W-1:0]          raddr;
    logic [lkc_pkg::KEY_W-1:0] rkey;
    logic [AGE_BITS-1:0]       rage;

    lkc_key u_key
    (
        .side         (side),
        .style        (style),
        .header       (header),
        .item_count   (item_count),
        .left_x       (left_x),
        .left_absent  (left_absent),
        .right_x      (right_x),
        .right_absent (right_absent),
        .canvas_w     (canvas_w_reg),
        .key          (key_w)
    );

    lkc_store
    #(
        .ENTRIES  (ENTRIES),
        .AGE_BITS (AGE_BITS),
        .IDX_W    (IDX_W)
    )
    u_store
    (
        .clk   (clk),
        .wctl  (wctl),
        .waddr (waddr),
        .wkey  (wkey),
        .wage  (wage),
        .raddr (raddr),
        .rkey  (rkey),
        .rage  (rage)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign slot      = slot_reg;
    assign evicted   = evicted_reg;
    assign cnt_inc   = cnt_reg + AGE_BITS'(1);

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        cnt_next       = cnt_reg;
        fill_next      = fill_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        least_next     = least_reg;
        lru_next       = lru_reg;
        res_hit_next   = res_hit_reg;
        res_slot_next  = res_slot_reg;
        res_ev_next    = res_ev_reg;
        out_valid_next = out_valid_reg && out_stall;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        evicted_next   = evicted_reg;
        wctl           = '0;
        waddr          = '0;
        wkey           = key_reg;
        wage           = cnt_reg;
        raddr          = rd_idx_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    key_next    = key_w;
                    rd_idx_next = '0;
                    pend_next   = 1'b0;
                    least_next  = '1;
                    lru_next    = '0;
                    if (cnt_inc == '1)
                    begin
                        cnt_next   = AGE_BITS'(1);
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        cnt_next   = cnt_inc;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SWEEP:
            begin
                if (rd_idx_reg < fill_reg)
                begin
                    wctl.age_we = 1'b1;
                    waddr       = rd_idx_reg[IDX_W-1:0];
                    wage        = AGE_BITS'(1);
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                else
                begin
                    rd_idx_next = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (pend_reg && rkey == key_reg)
                begin
                    wctl.age_we   = 1'b1;
                    waddr         = pend_idx_reg;
                    res_hit_next  = 1'b1;
                    res_slot_next = pend_idx_reg;
                    res_ev_next   = 1'b0;
                    pend_next     = 1'b0;
                    state_next    = ST_OUT;
                end
                else
                begin
                    if (pend_reg && rage < least_reg)
                    begin
                        least_next = rage;
                        lru_next   = pend_idx_reg;
                    end
                    if (rd_idx_reg < fill_reg)
                    begin
                        pend_next     = 1'b1;
                        pend_idx_next = rd_idx_reg[IDX_W-1:0];
                        rd_idx_next   = rd_idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        if (!pend_reg)
                        begin
                            // miss: fill a free slot or replace the LRU one
                            wctl.key_we  = 1'b1;
                            wctl.age_we  = 1'b1;
                            res_hit_next = 1'b0;
                            if (fill_reg == CNT_W'(ENTRIES))
                            begin
                                waddr         = lru_reg;
                                res_slot_next = lru_reg;
                                res_ev_next   = 1'b1;
                            end
                            else
                            begin
                                waddr         = fill_reg[IDX_W-1:0];
                                res_slot_next = fill_reg[IDX_W-1:0];
                                res_ev_next   = 1'b0;
                                fill_next     = fill_reg + CNT_W'(1);
                            end
                            state_next = ST_OUT;
                        end
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = res_hit_reg;
                    slot_next      = lkc_pkg::SLOT_W'(res_slot_reg);
                    evicted_next   = res_ev_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            canvas_w_reg  <= lkc_pkg::SCREEN_RESET;
            cnt_reg       <= '0;
            fill_reg      <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            slot_reg      <= '0;
            evicted_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fill_reg      <= fill_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
            slot_reg      <= slot_next;
            evicted_reg   <= evicted_next;
            if (cfg_valid && cfg_ready)
            begin
                canvas_w_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        pend_idx_reg <= pend_idx_next;
        least_reg    <= least_next;
        lru_reg      <= lru_next;
        res_hit_reg  <= res_hit_next;
        res_slot_reg <= res_slot_next;
        res_ev_reg   <= res_ev_next;
    end

endmodule
